// ===== rtl/rd_pkg.sv =====
// ----------------------------------------------------------------------------
// rd_pkg: shared definitions for the restoring divider
// Port widths and the command word from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package rd_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEFAULT_WIDTH = 32;

  typedef struct packed {
    logic load;     // latch operands, clear partial remainder
    logic step;     // one restoring iteration
    logic publish;  // copy result into the output register
    logic taken;    // output word consumed downstream
  } rd_cmd_t;

endpackage

// ===== rtl/rd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rd_ctrl: sequencer for the restoring divider
// Runs WIDTH iterations per word and manages the output register handshake.
// ----------------------------------------------------------------------------
module rd_ctrl #(
  parameter int unsigned WIDTH = rd_pkg::DEFAULT_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rd_pkg::rd_cmd_t cmd_o
);
  import rd_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_PUB
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            slot_free;
  logic            accept;
  logic            last;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign last      = (cnt_q == CntW'(WIDTH - 1));
  // a new word may enter while the previous result is being published
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_PUB) && slot_free));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.step    = (state_q == ST_BUSY);
    cmd_o.publish = (state_q == ST_PUB) && slot_free;
    cmd_o.taken   = out_valid_q && !out_stall_i;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (cmd_o.taken) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_BUSY;
            cnt_q   <= '0;
          end
        end
        ST_BUSY: begin
          cnt_q <= cnt_q + CntW'(1);
          if (last) begin
            state_q <= ST_PUB;
          end
        end
        ST_PUB: begin
          if (accept) begin
            state_q <= ST_BUSY;
            cnt_q   <= '0;
          end else if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rd_dp.sv =====
// ----------------------------------------------------------------------------
// rd_dp: restoring divider datapath
// Partial remainder, shifting dividend/quotient register and output register.
// ----------------------------------------------------------------------------
module rd_dp #(
  parameter int unsigned WIDTH = rd_pkg::DEFAULT_WIDTH
) (
  input  logic                      clk_i,
  input  rd_pkg::rd_cmd_t           cmd_i,
  input  logic [rd_pkg::DATA_W-1:0] dividend_i,
  input  logic [rd_pkg::DATA_W-1:0] divisor_i,
  output logic [rd_pkg::DATA_W-1:0] quotient_o,
  output logic [rd_pkg::DATA_W-1:0] remainder_o,
  output logic                      divide_by_zero_o
);
  import rd_pkg::*;

  logic [WIDTH-1:0]  rem_q, rem_d;
  logic [WIDTH-1:0]  num_q, num_d;   // dividend bits out at the top, quotient bits in
  logic [WIDTH-1:0]  den_q;
  logic              dz_q;
  logic [WIDTH:0]    rem_shift;
  logic [WIDTH:0]    diff;
  logic              ge;
  logic [DATA_W-1:0] quo_q, rem_out_q;
  logic              dz_out_q;

  // remainder kept one bit wider during the trial so large divisors work
  assign rem_shift = {rem_q, num_q[WIDTH-1]};
  assign ge        = (rem_shift >= {1'b0, den_q});
  assign diff      = rem_shift - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    if (cmd_i.load) begin
      rem_d = '0;
      num_d = WIDTH'(dividend_i);
    end else if (cmd_i.step) begin
      rem_d = ge ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
      num_d = {num_q[WIDTH-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (cmd_i.load) begin
      den_q <= WIDTH'(divisor_i);
      dz_q  <= (WIDTH'(divisor_i) == '0);
    end
    if (cmd_i.publish) begin
      quo_q     <= dz_q ? '0 : DATA_W'(num_q);
      rem_out_q <= dz_q ? '0 : DATA_W'(rem_q);
      dz_out_q  <= dz_q;
    end
  end

  assign quotient_o       = quo_q;
  assign remainder_o      = rem_out_q;
  assign divide_by_zero_o = dz_out_q;

endmodule

// ===== rtl/restoring_divider_u32.sv =====
// ----------------------------------------------------------------------------
// restoring_divider_u32: unsigned restoring divider
// One quotient bit per cycle, MSB first; zero divisor flags and returns zeros.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o | dividend_i, divisor_i
//  out      | out_valid_o/ out_stall_i| quotient_o, remainder_o, divide_by_zero_o
//
//  A word runs WIDTH iterations and then loads the output
//  register; a new word cannot start before the last is through its
//  iterations, as all words share the single subtract-and-restore step.
//  The next word is taken in the cycle its predecessor moves to the output
//  register, so a waiting result does not block input unless that register is
//  still full at the end of the iterations.
//  Reset clears the sequencer and the output valid; datapath is not reset.
// ----------------------------------------------------------------------------
module restoring_divider_u32 #(
  parameter int unsigned WIDTH = rd_pkg::DEFAULT_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [rd_pkg::DATA_W-1:0] dividend_i,
  input  logic [rd_pkg::DATA_W-1:0] divisor_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rd_pkg::DATA_W-1:0] quotient_o,
  output logic [rd_pkg::DATA_W-1:0] remainder_o,
  output logic                      divide_by_zero_o
);
  import rd_pkg::*;

  rd_cmd_t cmd;

  rd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

// ===== sim/tb_restoring_divider_u32.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restoring_divider_u32: self-checking bench for the unsigned divider
// Drives operand words through the valid/stall input, predicts quotient,
// remainder and the zero-divisor flag per word, and checks every output word
// in order. It runs four idling mixes, one long output hold-off and a
// full drain after each of the last three mixes.
// ----------------------------------------------------------------------------
module tb_restoring_divider_u32;

  import rd_pkg::*;

  localparam int unsigned OPW        = DEFAULT_WIDTH;
  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned SHOW_MAX   = 10;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } div_result_t;

  // quotient/remainder board: predicts on accepted operands, checks in order
  class quot_board;
    div_result_t owed[$];
    int unsigned fails;

    function div_result_t divide_word(logic [DATA_W-1:0] num_w, logic [DATA_W-1:0] den_w);
      div_result_t res;
      bit [63:0]   mask;
      bit [63:0]   num;
      bit [63:0]   den;
      bit [63:0]   part;
      bit [63:0]   quo;
      bit          carry;
      mask = (OPW >= 64) ? {64{1'b1}} : ((64'd1 << OPW) - 64'd1);
      num  = 64'(num_w) & mask;
      den  = 64'(den_w) & mask;
      part = '0;
      quo  = '0;
      res  = '0;
      if (den == 0) begin
        res.divide_by_zero = 1'b1;
        return res;
      end
      // partial remainder effectively OPW+1 bits: carry holds the bit shifted out
      for (int i = OPW - 1; i >= 0; i--) begin
        carry = part[OPW-1];
        part  = ((part << 1) | 64'(num[i])) & mask;
        if (carry || part >= den) begin
          part   = (part - den) & mask;
          quo[i] = 1'b1;
        end
      end
      res.quotient  = quo[DATA_W-1:0];
      res.remainder = part[DATA_W-1:0];
      return res;
    endfunction

    function void note(logic [DATA_W-1:0] num_w, logic [DATA_W-1:0] den_w);
      owed.push_back(divide_word(num_w, den_w));
    endfunction

    function void check(div_result_t got);
      div_result_t want;
      if (owed.size() == 0) begin
        fails++;
        if (fails <= SHOW_MAX)
          $display("%0t unexpected word: q=%h r=%h dbz=%b", $time,
                   got.quotient, got.remainder, got.divide_by_zero);
        return;
      end
      want = owed.pop_front();
      if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
          got.divide_by_zero !== want.divide_by_zero) begin
        fails++;
        if (fails <= SHOW_MAX)
          $display("%0t mismatch: exp q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b", $time,
                   want.quotient, want.remainder, want.divide_by_zero,
                   got.quotient, got.remainder, got.divide_by_zero);
      end
    endfunction

    function void close();
      if (owed.size() != 0) begin
        fails += owed.size();
        $display("%0d words never came out", owed.size());
      end
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] dividend_i       = '0;
  logic [DATA_W-1:0] divisor_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [DATA_W-1:0] quotient_o;
  logic [DATA_W-1:0] remainder_o;
  logic              divide_by_zero_o;

  quot_board   board       = new();
  int unsigned snd_idle_pct = 18;
  int unsigned rcv_idle_pct = 49;
  int unsigned hold_req     = 0;
  int unsigned hold_left    = 0;
  int unsigned cycles       = 0;

  restoring_divider_u32 u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_restoring_divider_u32: errors");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check('{quotient_o, remainder_o, divide_by_zero_o});
  end

  // entered and left at a falling edge; valid stays up after the word
  task automatic send_word(input logic [DATA_W-1:0] num, input logic [DATA_W-1:0] den);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    dividend_i = num;
    divisor_i  = den;
    do @(posedge clk_i); while (in_stall_o);
    board.note(num, den);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
  endtask

  // idle mixes and hold requests change at a rising edge, away from the receiver
  task automatic set_mix(input int unsigned snd, input int unsigned rcv, input int unsigned hold);
    in_valid_i = 1'b0;
    @(posedge clk_i);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    hold_req     = hold;
    @(negedge clk_i);
  endtask

  function automatic void pick_operands(output logic [DATA_W-1:0] num,
                                        output logic [DATA_W-1:0] den);
    case ($urandom_range(9))
      0: begin
        num = $urandom;
        den = '0;
      end
      1: begin  // tiny divisor, long quotient
        num = $urandom;
        den = $urandom_range(16, 1);
      end
      2: begin  // top bit set, needs the extra remainder bit
        num = $urandom;
        den = $urandom | 32'h8000_0000;
      end
      3: begin  // dividend below divisor
        den = $urandom | 32'h1;
        num = $urandom % den;
      end
      4: begin  // multiple of the divisor, wrapped at 32 bits
        den = ($urandom >> $urandom_range(31)) | 32'h1;
        num = den * $urandom_range(1000, 1);
      end
      5: begin
        num = 32'hFFFF_FFFF - $urandom_range(3);
        den = $urandom >> $urandom_range(31);
      end
      default: begin
        num = $urandom;
        den = $urandom >> $urandom_range(31);
      end
    endcase
  endfunction

  task automatic random_words(input int unsigned count);
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    repeat (count) begin
      pick_operands(num, den);
      send_word(num, den);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corner operands: zero divisor, unit divisor, all-ones, top-bit divisors
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h1234_5678, 32'h0000_0000);
    send_word(32'h0000_0000, 32'h0000_0001);
    send_word(32'hFFFF_FFFF, 32'h0000_0001);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_word(32'h8000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h8000_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h8000_0000);
    send_word(32'hFFFF_FFFF, 32'h8000_0001);
    send_word(32'hFFFF_FFFF, 32'h0000_0002);
    send_word(32'h0000_0005, 32'h0000_0007);
    send_word(32'h0000_0064, 32'h0000_000A);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    send_word(32'h5555_5555, 32'hAAAA_AAAA);
    send_word(32'hDEAD_BEEF, 32'h0000_0003);
    send_word(32'hFFFF_FFFF, 32'h0001_0001);

    random_words(250);

    // output held off while words keep coming: the block fills and stalls input
    set_mix(0, 49, HOLD_LEN);
    random_words(20);
    drain();

    set_mix(49, 18, 0);
    random_words(300);
    drain();

    set_mix(0, 0, 0);
    random_words(220);
    drain();

    repeat (2 * (OPW + 1)) @(posedge clk_i);
    board.close();
    if (board.fails == 0) begin
      $display("tb_restoring_divider_u32: clean");
    end else begin
      $display("tb_restoring_divider_u32: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rd_pkg.sv
rtl/rd_ctrl.sv
rtl/rd_dp.sv
rtl/restoring_divider_u32.sv
sim/tb_restoring_divider_u32.sv
